// ===== hw/rtl/bcfp_pkg.sv =====
`default_nettype none
package bcfp_pkg;

  localparam int unsigned BCFP_MAX_FRAME_LEN = 65535;
  localparam int unsigned BCFP_QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_OPEN = 8'h7B;
  localparam logic [7:0] CH_CLOSE = 8'h7D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_ONE = 8'h31;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_B = 8'h42;

  localparam logic [3:0] CMD_NONE = 4'd0;
  localparam logic [3:0] CMD_ONE_LINE = 4'd3;
  localparam logic [3:0] CMD_FULL_SCREEN = 4'd4;
  localparam logic [3:0] CMD_FIXED = 4'd6;
  localparam logic [3:0] CMD_CIVIL = 4'd7;
  localparam logic [3:0] CMD_BRIGHT = 4'd8;
  localparam logic [3:0] CMD_VOLUME = 4'd9;
  localparam logic [3:0] CMD_PERIPH = 4'd10;
  localparam logic [3:0] CMD_VOICE = 4'd11;

  localparam logic [16:0] FEE_MAX = 17'd99999;
  localparam int unsigned RESULT_BITS = 96;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_FRAME = 2'd1,
    ST_CMD = 2'd2,
    ST_PARAM = 2'd3
  } status_t;

  // frame summary handed from front to back
  typedef struct packed {
    logic        shape_ok;
    logic        len_ok;
    logic [3:0]  command;
    logic [7:0]  decl_len;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic        digit_error;
    logic [16:0] fee;
  } frame_t;

  typedef struct packed {
    logic [7:0]  payload_len;
    logic [16:0] fee_amount;
    logic [7:0]  kind;
    logic [7:0]  ctrl_byte;
    logic [7:0]  level;
    logic [7:0]  pos_y;
    logic [7:0]  pos_x;
    logic [7:0]  row;
    logic [7:0]  color;
    logic [7:0]  decl_len;
    logic [3:0]  command;
    status_t     status;
  } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bcfp_front.sv =====
`default_nettype none
module bcfp_front #(
  parameter int unsigned MAX_FRAME_LEN = bcfp_pkg::BCFP_MAX_FRAME_LEN
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [7:0]      frame_byte,
  input  wire logic            is_last,
  output logic                 push,
  output bcfp_pkg::frame_t     frame
);
  import bcfp_pkg::*;

  localparam int PosRaw = $clog2(MAX_FRAME_LEN + 1);
  localparam int PosW = (PosRaw < 4) ? 4 : PosRaw;
  localparam int CmpW = (PosW > 8) ? PosW : 8;

  logic [PosW-1:0] pos;
  logic            start_seen;
  logic [3:0]      command_code;
  logic [7:0]      declared_length;
  logic [7:0]      data_byte_zero;
  logic [7:0]      data_byte_one;
  logic [7:0]      data_byte_two;
  logic            digit_error;
  logic [16:0]     fee;

  logic            too_long;
  logic            is_digit;
  logic            fee_slot;
  logic [3:0]      mapped;
  logic [16:0]     fee_next;

  assign too_long = pos >= PosW'(MAX_FRAME_LEN);
  assign is_digit = (frame_byte >= CH_ZERO) && (frame_byte <= CH_NINE);
  assign fee_slot = (pos >= PosW'(4)) && (pos <= PosW'(8));
  assign fee_next = (fee << 3) + (fee << 1) + 17'(frame_byte - CH_ZERO);

  always_comb begin
    if ((frame_byte >= CH_ONE) && (frame_byte <= CH_NINE)) begin
      mapped = frame_byte[3:0];
    end else if (frame_byte == CH_UPPER_A) begin
      mapped = CMD_PERIPH;
    end else if (frame_byte == CH_UPPER_B) begin
      mapped = CMD_VOICE;
    end else begin
      mapped = CMD_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      pos <= '0;
      start_seen <= 1'b0;
      command_code <= CMD_NONE;
      declared_length <= '0;
      data_byte_zero <= '0;
      data_byte_one <= '0;
      data_byte_two <= '0;
      digit_error <= 1'b0;
      fee <= '0;
    end else begin
      push <= accept && is_last;
      if (accept && is_last) begin
        frame.shape_ok <= !too_long && (pos >= PosW'(3)) && start_seen &&
                          (frame_byte == CH_CLOSE);
        frame.len_ok <= (CmpW'(pos) - CmpW'(3)) >= CmpW'(declared_length);
        frame.command <= command_code;
        frame.decl_len <= declared_length;
        frame.byte0 <= data_byte_zero;
        frame.byte1 <= data_byte_one;
        frame.byte2 <= data_byte_two;
        frame.digit_error <= digit_error;
        frame.fee <= fee;
        pos <= '0;
        start_seen <= 1'b0;
        command_code <= CMD_NONE;
        declared_length <= '0;
        data_byte_zero <= '0;
        data_byte_one <= '0;
        data_byte_two <= '0;
        digit_error <= 1'b0;
        fee <= '0;
      end else if (accept) begin
        case (pos)
          PosW'(0): start_seen <= (frame_byte == CH_OPEN);
          PosW'(1): command_code <= mapped;
          PosW'(2): declared_length <= frame_byte;
          PosW'(3): data_byte_zero <= frame_byte;
          PosW'(4): data_byte_one <= frame_byte;
          PosW'(5): data_byte_two <= frame_byte;
          default: ;
        endcase
        if (fee_slot && !digit_error) begin
          if (is_digit) begin
            fee <= fee_next;
          end else begin
            digit_error <= 1'b1;
          end
        end
        if (!too_long) begin
          pos <= pos + PosW'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bcfp_queue.sv =====
`default_nettype none
module bcfp_queue #(
  parameter int unsigned DEPTH = bcfp_pkg::BCFP_QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire bcfp_pkg::frame_t push_data,
  input  wire logic             pop,
  output logic                  full,
  output logic                  almost_full,
  output logic                  not_empty,
  output bcfp_pkg::frame_t      head
);
  import bcfp_pkg::*;

  localparam int AddrW = (DEPTH < 2) ? 1 : $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  frame_t            entries [DEPTH];
  logic [AddrW-1:0]  wr_ptr;
  logic [AddrW-1:0]  rd_ptr;
  logic [CntW-1:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full = count == CntW'(DEPTH);
  assign almost_full = count == CntW'(DEPTH - 1);
  assign not_empty = count != '0;
  assign do_push = push && !full;
  assign do_pop = pop && not_empty;
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AddrW'(DEPTH - 1)) ? '0 : wr_ptr + AddrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AddrW'(DEPTH - 1)) ? '0 : rd_ptr + AddrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bcfp_back.sv =====
`default_nettype none
module bcfp_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             head_valid,
  input  wire bcfp_pkg::frame_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output bcfp_pkg::result_t     result
);
  import bcfp_pkg::*;

  result_t     r;
  logic [7:0]  d;
  logic [7:0]  digit0;
  logic [7:0]  digit1;

  assign pop = head_valid && (!out_valid || out_ready);
  assign d = head.decl_len;
  assign digit0 = head.byte0 - CH_ZERO;
  assign digit1 = head.byte1 - CH_ONE;

  always_comb begin
    r = '0;
    r.status = ST_OK;
    if (!head.shape_ok) begin
      r.status = ST_FRAME;
    end else if (head.command == CMD_NONE) begin
      r.status = ST_CMD;
    end else if (!head.len_ok) begin
      r.status = ST_FRAME;
      r.command = head.command;
    end else begin
      r.command = head.command;
      r.decl_len = d;
      case (head.command)
        CMD_ONE_LINE: begin
          if (d < 8'd2) begin
            r.status = ST_PARAM;
          end else begin
            r.color = digit0;
            r.row = digit1;
            r.payload_len = d - 8'd2;
            if (digit0 > 8'd2 || digit1 > 8'd4) r.status = ST_PARAM;
          end
        end
        CMD_FULL_SCREEN: begin
          if (d < 8'd3) begin
            r.status = ST_PARAM;
          end else begin
            r.color = digit0;
            r.pos_x = head.byte1;
            r.pos_y = head.byte2;
            r.payload_len = d - 8'd3;
            if (digit0 > 8'd2) r.status = ST_PARAM;
          end
        end
        CMD_BRIGHT: begin
          if (d < 8'd1) begin
            r.status = ST_PARAM;
          end else begin
            r.level = digit0;
            if (digit0 > 8'd5) r.status = ST_PARAM;
          end
        end
        CMD_VOLUME: begin
          if (d < 8'd1) begin
            r.status = ST_PARAM;
          end else begin
            r.level = digit0;
            if (digit0 < 8'd1 || digit0 > 8'd5) r.status = ST_PARAM;
          end
        end
        CMD_PERIPH: begin
          if (d < 8'd1) begin
            r.status = ST_PARAM;
          end else begin
            r.ctrl_byte = head.byte0;
          end
        end
        CMD_CIVIL: begin
          if (d < 8'd1) begin
            r.status = ST_PARAM;
          end else begin
            r.kind = digit0;
            if (digit0 > 8'd3) r.status = ST_PARAM;
          end
        end
        CMD_FIXED: begin
          if (d < 8'd2) begin
            r.status = ST_PARAM;
          end else begin
            r.kind = digit0;
            r.payload_len = d - 8'd1;
            if (digit0 > 8'd1) r.status = ST_PARAM;
          end
        end
        CMD_VOICE: begin
          if (d < 8'd6) begin
            r.status = ST_PARAM;
          end else begin
            r.kind = digit0;
            r.fee_amount = head.fee;
            if (head.digit_error) r.status = ST_PARAM;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        result <= r;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/brace_command_frame_parser_core.sv =====
// after tlast, a frame passes the front register, a queue entry and the back's
// result register; one byte per cycle and a result per frame, down to one per cycle,
// except that s_tready drops while the frame queue between front and back is full,
// or while a frame still on its way into the queue would take its last free entry
// rst is synchronous and active high; it clears parser state, queue and output valid
`default_nettype none
module brace_command_frame_parser_core #(
  parameter int unsigned MAX_FRAME_LEN = bcfp_pkg::BCFP_MAX_FRAME_LEN,
  parameter int unsigned QUEUE_DEPTH = bcfp_pkg::BCFP_QUEUE_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [7:0]                        s_tdata,  // frame_byte
  input  wire logic                              s_tlast,  // is_last
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // status, command, decl_len, color, row, pos_x, pos_y, level, ctrl_byte,
  // kind, fee_amount, payload_len, one zero pad bit
  output logic [bcfp_pkg::RESULT_BITS-1:0]       m_tdata
);
  import bcfp_pkg::*;

  logic    accept;
  logic    push;
  frame_t  frame;
  logic    q_full;
  logic    q_almost_full;
  logic    q_valid;
  frame_t  q_head;
  logic    pop;
  result_t result;

  assign s_tready = !q_full && !(push && q_almost_full && !pop);
  assign accept = s_tvalid && s_tready;
  assign m_tdata = RESULT_BITS'(result);

  bcfp_front #(
    .MAX_FRAME_LEN(MAX_FRAME_LEN)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .frame_byte(s_tdata),
    .is_last(s_tlast),
    .push(push),
    .frame(frame)
  );

  bcfp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(frame),
    .pop(pop),
    .full(q_full),
    .almost_full(q_almost_full),
    .not_empty(q_valid),
    .head(q_head)
  );

  bcfp_back u_back (
    .clk(clk),
    .rst(rst),
    .head_valid(q_valid),
    .head(q_head),
    .pop(pop),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .result(result)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/bcfp_checker.sv =====
`default_nettype none
module bcfp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [95:0] m_tdata
);
  import bcfp_pkg::*;

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == ST_OK || m_tdata[1:0] == ST_PARAM)
      |-> m_tdata[5:2] != CMD_NONE)
    else $error("accepted frame without command");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == ST_CMD |-> m_tdata[95:2] == '0)
    else $error("bad command result carries fields");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[86:70] <= FEE_MAX)
    else $error("fee amount out of range");

endmodule

bind brace_command_frame_parser_core bcfp_checker u_bcfp_checker (
  .clk(clk),
  .rst(rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata)
);
`default_nettype wire
